[hdl/hpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hpd_pkg;

   // Fraction bits of the 8.8 gains.
   localparam int FracBits = 8;

   // Configuration register indexes.
   localparam logic [2:0] CSR_GAIN_P           = 3'd0;
   localparam logic [2:0] CSR_GAIN_I           = 3'd1;
   localparam logic [2:0] CSR_GAIN_D           = 3'd2;
   localparam logic [2:0] CSR_FUNCTIONAL_RANGE = 3'd3;
   localparam logic [2:0] CSR_INTEGRAL_MIN     = 3'd4;
   localparam logic [2:0] CSR_INTEGRAL_MAX     = 3'd5;
   localparam logic [2:0] CSR_MAX_DUTY         = 3'd6;
   localparam logic [2:0] CSR_PWM_TOP          = 3'd7;

   // Request payload: one temperature sample.
   typedef struct packed {
      logic signed [10:0] measured_temp;
      logic        [9:0]  setpoint_temp;
   } req_type;

   // Response payload: one duty value.
   typedef struct packed {
      logic [9:0] duty;
      logic       integral_active;
   } rsp_type;

   // Configuration register bank.
   typedef struct packed {
      logic        [15:0] gain_p;
      logic        [15:0] gain_i;
      logic        [15:0] gain_d;
      logic        [9:0]  functional_range;
      logic signed [15:0] integral_min;
      logic        [14:0] integral_max;
      logic        [9:0]  max_duty;
      logic        [9:0]  pwm_top;
   } cfg_type;

   // Front stage result: error terms and the updated integral.
   typedef struct packed {
      logic signed [11:0] err;
      logic signed [11:0] delta;
      logic signed [15:0] integral;
      logic               active;
      logic               target_zero;
   } front_type;

   // Product stage result: shifted P, I and D terms.
   typedef struct packed {
      logic signed [20:0] p_term;
      logic signed [24:0] i_term;
      logic signed [20:0] d_term;
      logic               active;
      logic               target_zero;
   } term_type;

endpackage

`default_nettype wire

[hdl/hpd_csr.sv]
`timescale 1ns / 1ps
`default_nettype none

module hpd_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [15:0]    csr_wdata,
   output hpd_pkg::cfg_type    cfg
);

   hpd_pkg::cfg_type cfg_ff;
   hpd_pkg::cfg_type cfg_in;

   // Every write is taken in the cycle it is offered.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode one register write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            hpd_pkg::CSR_GAIN_P:           cfg_in.gain_p           = csr_wdata;
            hpd_pkg::CSR_GAIN_I:           cfg_in.gain_i           = csr_wdata;
            hpd_pkg::CSR_GAIN_D:           cfg_in.gain_d           = csr_wdata;
            hpd_pkg::CSR_FUNCTIONAL_RANGE: cfg_in.functional_range = csr_wdata[9:0];
            hpd_pkg::CSR_INTEGRAL_MIN:     cfg_in.integral_min     = $signed(csr_wdata);
            hpd_pkg::CSR_INTEGRAL_MAX:     cfg_in.integral_max     = csr_wdata[14:0];
            hpd_pkg::CSR_MAX_DUTY:         cfg_in.max_duty         = csr_wdata[9:0];
            hpd_pkg::CSR_PWM_TOP:          cfg_in.pwm_top          = csr_wdata[9:0];
            default:                       cfg_in                  = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= 16'd256;
         cfg_ff.gain_i           <= 16'd16;
         cfg_ff.gain_d           <= 16'd256;
         cfg_ff.functional_range <= 10'd10;
         cfg_ff.integral_min     <= -16'sd32768;
         cfg_ff.integral_max     <= 15'd32767;
         cfg_ff.max_duty         <= 10'd255;
         cfg_ff.pwm_top          <= 10'd250;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hpd_front (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hpd_pkg::cfg_type cfg,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire hpd_pkg::req_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output hpd_pkg::front_type  out_data
);

   logic               valid_ff;
   logic               valid_in;
   hpd_pkg::front_type data_ff;
   hpd_pkg::front_type data_in;
   logic signed [10:0] prev_ff;
   logic signed [15:0] integral_ff;
   logic signed [15:0] integral_in;
   logic               advance;
   logic signed [11:0] err;
   logic signed [11:0] delta;
   logic        [10:0] mag;
   logic               active;
   logic signed [16:0] sum;
   logic signed [16:0] sum_lo;
   logic signed [16:0] sum_hi;

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = advance || (valid_ff && !out_ready);

   // Error, delta and the range test.
   always_comb begin
      err    = $signed({2'b00, in_data.setpoint_temp}) - 12'(in_data.measured_temp);
      delta  = 12'(in_data.measured_temp) - 12'(prev_ff);
      mag    = err[11] ? 11'(-err) : 11'(err);
      active = mag < {1'b0, cfg.functional_range};
   end

   // Accumulate the error and apply the lower clamp, then the upper one; outside the range the integral is cleared.
   always_comb begin
      sum    = 17'(integral_ff) + 17'(err);
      sum_lo = (sum < 17'(cfg.integral_min)) ? 17'(cfg.integral_min) : sum;
      sum_hi = (sum_lo > $signed({2'b00, cfg.integral_max}))
               ? $signed({2'b00, cfg.integral_max}) : sum_lo;
      integral_in = active ? sum_hi[15:0] : 16'sd0;
   end

   always_comb begin
      data_in.err         = err;
      data_in.delta       = delta;
      data_in.integral    = integral_in;
      data_in.active      = active;
      data_in.target_zero = (in_data.setpoint_temp == 10'd0);
   end

   // Controller state moves with each transfer into this stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         prev_ff     <= 11'sd0;
         integral_ff <= 16'sd0;
      end else begin
         valid_ff <= valid_in;
         if (advance) begin
            prev_ff     <= in_data.measured_temp;
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hpd_mult.sv]
`timescale 1ns / 1ps
`default_nettype none

module hpd_mult (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hpd_pkg::cfg_type cfg,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire hpd_pkg::front_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output hpd_pkg::term_type   out_data
);

   logic               valid_ff;
   logic               valid_in;
   hpd_pkg::term_type  data_ff;
   hpd_pkg::term_type  data_in;
   logic               advance;
   logic signed [28:0] prod_p;
   logic signed [32:0] prod_i;
   logic signed [28:0] prod_d;

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = advance || (valid_ff && !out_ready);

   // Three gain products in parallel; the shift floors toward minus infinity. I and D are zero when inactive.
   always_comb begin
      prod_p = $signed({1'b0, cfg.gain_p}) * in_data.err;
      prod_i = $signed({1'b0, cfg.gain_i}) * in_data.integral;
      prod_d = $signed({1'b0, cfg.gain_d}) * in_data.delta;
      data_in.p_term      = prod_p[28:hpd_pkg::FracBits];
      data_in.i_term      = in_data.active ? prod_i[32:hpd_pkg::FracBits] : 25'sd0;
      data_in.d_term      = in_data.active ? prod_d[28:hpd_pkg::FracBits] : 21'sd0;
      data_in.active      = in_data.active;
      data_in.target_zero = in_data.target_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hpd_clamp.sv]
`timescale 1ns / 1ps
`default_nettype none

module hpd_clamp (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire hpd_pkg::cfg_type cfg,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire hpd_pkg::term_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output hpd_pkg::rsp_type    out_data
);

   logic               valid_ff;
   logic               valid_in;
   hpd_pkg::rsp_type   data_ff;
   hpd_pkg::rsp_type   data_in;
   logic               advance;
   logic signed [25:0] total;
   logic        [9:0]  duty_lim;
   logic        [9:0]  duty_on;

   assign in_ready  = !valid_ff || out_ready;
   assign advance   = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = advance || (valid_ff && !out_ready);

   // Sum the terms, clamp to the duty range, gate on heater off, then limit to the top.
   always_comb begin
      total = 26'(in_data.p_term) + 26'(in_data.i_term) - 26'(in_data.d_term);
      if (total < 26'sd0) begin
         duty_lim = 10'd0;
      end else if (total > $signed({16'd0, cfg.max_duty})) begin
         duty_lim = cfg.max_duty;
      end else begin
         duty_lim = total[9:0];
      end
      duty_on = in_data.target_zero ? 10'd0 : duty_lim;
      data_in.duty            = (duty_on > cfg.pwm_top) ? cfg.pwm_top : duty_on;
      data_in.integral_active = in_data.active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

[hdl/heater_pid_duty_controller.sv]
// Heater PID duty controller. Each transfer on the request channel carries one
// measured and one target temperature and yields exactly one duty value on the
// response channel, in order. One sample can be taken every clock cycle while
// the response side does not stall. Each sample passes through four register
// stages: input register, error and integral stage (which holds the previous
// temperature and the integral and updates both with each transfer), gain
// product stage, and the clamp stage that feeds the response register. A
// stalled response fills the stages one by one before the request side stalls.
// Configuration writes are taken at once and should be made only while no
// sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

module heater_pid_duty_controller (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire hpd_pkg::req_type req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output hpd_pkg::rsp_type    rsp_data,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [15:0]    csr_wdata
);

   hpd_pkg::cfg_type   cfg;
   logic               in_valid_ff;
   logic               in_valid_in;
   hpd_pkg::req_type   in_data_ff;
   logic               in_ready;
   logic               front_ready;
   logic               front_valid;
   hpd_pkg::front_type front_data;
   logic               mult_ready;
   logic               mult_valid;
   hpd_pkg::term_type  mult_data;
   logic               clamp_ready;
   logic               req_take;

   hpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input register.
   assign in_ready    = !in_valid_ff || front_ready;
   assign req_stall   = !in_ready;
   assign req_take    = req_valid && in_ready;
   assign in_valid_in = req_take || (in_valid_ff && !front_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   hpd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (front_ready),
      .in_data   (in_data_ff),
      .out_valid (front_valid),
      .out_ready (mult_ready),
      .out_data  (front_data)
   );

   hpd_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (front_valid),
      .in_ready  (mult_ready),
      .in_data   (front_data),
      .out_valid (mult_valid),
      .out_ready (clamp_ready),
      .out_data  (mult_data)
   );

   hpd_clamp u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (mult_valid),
      .in_ready  (clamp_ready),
      .in_data   (mult_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/hpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module hpd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire hpd_pkg::rsp_type rsp_data
);

   // A response held by stall keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // The request side stalls only when the pipeline is full behind a stalled response.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // A request transfer is followed by a valid response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> ##4 rsp_valid)
      else $error("accepted request did not reach the response register");

endmodule

bind heater_pid_duty_controller hpd_checker u_hpd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
